// File: design/llp_pkg.sv
// Package for the LL(1) parser: symbol, production and verdict codes plus table functions.
`timescale 1ns / 1ps
package llp_pkg;

	localparam int STACK_DEPTH_DEF = 64;

	localparam logic [3:0] SYM_END  = 4'd0;
	localparam logic [3:0] SYM_A_T  = 4'd1;
	localparam logic [3:0] SYM_B_T  = 4'd2;
	localparam logic [3:0] SYM_C_T  = 4'd3;
	localparam logic [3:0] SYM_LP   = 4'd4;
	localparam logic [3:0] SYM_RP   = 4'd5;
	localparam logic [3:0] SYM_S    = 4'd6;
	localparam logic [3:0] SYM_A    = 4'd7;
	localparam logic [3:0] SYM_B    = 4'd8;
	localparam logic [3:0] SYM_C    = 4'd9;
	localparam logic [3:0] SYM_D    = 4'd10;
	localparam logic [3:0] SYM_NONE = 4'd15;

	localparam logic [1:0] VER_OK       = 2'd0;
	localparam logic [1:0] VER_ACCEPT   = 2'd1;
	localparam logic [1:0] VER_REJECT   = 2'd2;
	localparam logic [1:0] VER_OVERFLOW = 2'd3;

	localparam logic [2:0] PR_NONE  = 3'd0;
	localparam logic [2:0] PR_ABC   = 3'd1;
	localparam logic [2:0] PR_A     = 3'd2;
	localparam logic [2:0] PR_EPS   = 3'd3;
	localparam logic [2:0] PR_B     = 3'd4;
	localparam logic [2:0] PR_PAREN = 3'd5;
	localparam logic [2:0] PR_C     = 3'd6;
	localparam logic [2:0] PR_AC    = 3'd7;

	localparam logic [1:0] STEP_FAIL   = 2'd0;
	localparam logic [1:0] STEP_OVF    = 2'd1;
	localparam logic [1:0] STEP_MATCH  = 2'd2;
	localparam logic [1:0] STEP_EXPAND = 2'd3;

	localparam logic [7:0] CH_END = "$";
	localparam logic [7:0] CH_A   = "a";
	localparam logic [7:0] CH_B   = "b";
	localparam logic [7:0] CH_C   = "c";
	localparam logic [7:0] CH_LP  = "(";
	localparam logic [7:0] CH_RP  = ")";

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] verdict;
		logic [2:0] prod;
		logic [1:0] len;
	} step_t;

	function automatic logic [3:0] classify(input logic [7:0] ch);
		logic [3:0] s;
		case (ch)
			CH_END:  s = SYM_END;
			CH_A:    s = SYM_A_T;
			CH_B:    s = SYM_B_T;
			CH_C:    s = SYM_C_T;
			CH_LP:   s = SYM_LP;
			CH_RP:   s = SYM_RP;
			default: s = SYM_NONE;
		endcase
		return s;
	endfunction

	// first production wins on a collision
	function automatic logic [2:0] predict(input logic [3:0] nt, input logic [3:0] t);
		logic [2:0] p;
		p = PR_NONE;
		case (nt)
			SYM_S: begin
				if (t inside {SYM_A_T, SYM_B_T, SYM_C_T, SYM_LP}) p = PR_ABC;
			end
			SYM_A: begin
				if (t == SYM_A_T) p = PR_A;
				else if (t inside {SYM_B_T, SYM_C_T, SYM_LP}) p = PR_EPS;
			end
			SYM_B: begin
				if (t == SYM_B_T) p = PR_B;
				else if (t inside {SYM_C_T, SYM_LP}) p = PR_EPS;
			end
			SYM_C: begin
				if (t == SYM_C_T) p = PR_C;
				else if (t == SYM_LP) p = PR_PAREN;
			end
			SYM_D: begin
				if (t inside {SYM_A_T, SYM_C_T, SYM_LP}) p = PR_AC;
			end
			default: p = PR_NONE;
		endcase
		return p;
	endfunction

	function automatic logic [1:0] prod_len(input logic [2:0] p);
		logic [1:0] n;
		case (p)
			PR_ABC, PR_PAREN:  n = 2'd3;
			PR_AC:             n = 2'd2;
			PR_A, PR_B, PR_C:  n = 2'd1;
			default:           n = 2'd0;
		endcase
		return n;
	endfunction

	// symbol i of production p, left to right
	function automatic logic [3:0] prod_sym(input logic [2:0] p, input logic [1:0] i);
		logic [3:0] s;
		s = SYM_END;
		case (p)
			PR_ABC:   s = (i == 2'd0) ? SYM_A : ((i == 2'd1) ? SYM_B : SYM_C);
			PR_PAREN: s = (i == 2'd0) ? SYM_LP : ((i == 2'd1) ? SYM_S : SYM_RP);
			PR_AC:    s = (i == 2'd0) ? SYM_A : SYM_C;
			PR_A:     s = SYM_A_T;
			PR_B:     s = SYM_B_T;
			PR_C:     s = SYM_C_T;
			default:  s = SYM_END;
		endcase
		return s;
	endfunction

endpackage

// File: design/llp_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module llp_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/llp_step.sv
// One parse step: match, predict lookup and overflow check for the stack top.
`timescale 1ns / 1ps
module llp_step import llp_pkg::*; #(
	parameter int DEPTH = STACK_DEPTH_DEF
) (
	input  logic [3:0]                 top,
	input  logic [3:0]                 tsym,
	input  logic [$clog2(DEPTH+1)-1:0] level,
	output step_t                      step
);

	localparam int LW = $clog2(DEPTH + 1);
	localparam logic [LW:0] DEPTH_W = (LW + 1)'(DEPTH);

	always_comb begin
		logic [LW:0] ext;
		logic [LW:0] need;
		logic [2:0]  p;
		logic [1:0]  n;
		ext  = {1'b0, level};
		p    = predict(top, tsym);
		n    = prod_len(p);
		need = ext - (LW + 1)'(1) + (LW + 1)'(n);
		step = '{kind: STEP_FAIL, verdict: VER_REJECT, prod: p, len: n};
		if (level == '0 || ext > DEPTH_W) begin
			step.kind = STEP_FAIL;
		end else if (top <= SYM_RP) begin
			step.kind = STEP_MATCH;
			if (top != tsym) step.verdict = VER_REJECT;
			else if (tsym == SYM_END) step.verdict = VER_ACCEPT;
			else step.verdict = VER_OK;
		end else if (top > SYM_D || tsym > SYM_RP || p == PR_NONE) begin
			step.kind = STEP_FAIL;
		end else if (need > DEPTH_W) begin
			step.kind    = STEP_OVF;
			step.verdict = VER_OVERFLOW;
		end else begin
			step.kind    = STEP_EXPAND;
			step.verdict = VER_OK;
		end
	end

endmodule

// File: design/ll1_table_driven_parser.sv
// Top level of the LL(1) predictive parser: sequencer, stack top register and stack RAM.
`timescale 1ns / 1ps
// Checks strings against S->ABC|D, A->a|eps, B->b|eps, C->(S)|c, D->AC, one character per
// request, and returns one result per request (verdict 0 consuming, 1 accepted, 2 rejected,
// 3 stack overflow; string_done marks the end-of-string result, after which the stack
// returns to end marker plus S). A request after the string has already failed or been
// accepted is answered straight from the sticky outcome. Otherwise the shared step unit
// examines the stack top in turn: a three-symbol production takes an extra push state to
// write two symbols through the single RAM write port, and each pop passes through a load
// state for the registered RAM read; the block takes no request meanwhile. The top of the
// stack lives in a register and the bottom end marker is implicit, so no clearing pass is
// needed after reset.
module ll1_table_driven_parser import llp_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [7:0] ch,
	input  logic       end_of_string,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [1:0] verdict,
	output logic       string_done
);

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXAM = 2'd1;
	localparam logic [1:0] S_PUSH = 2'd2;
	localparam logic [1:0] S_LOAD = 2'd3;

	logic [1:0]    state_q;
	logic [LW-1:0] level_q;
	logic [3:0]    top_q;
	logic [1:0]    failed_q;
	logic [3:0]    tsym_q;
	logic          end_q;
	logic          cont_q;
	logic [2:0]    prod_q;
	logic [AW-1:0] wr_idx_q;
	logic          res_valid_q;
	logic [1:0]    verdict_q;
	logic          done_q;

	step_t         st;
	logic [LW-1:0] lvl_m1;
	logic [LW-1:0] lvl_m2;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [3:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [3:0]    ram_rdata;
	logic          accept;

	llp_step #(.DEPTH(STACK_DEPTH)) u_step (
		.top   (top_q),
		.tsym  (tsym_q),
		.level (level_q),
		.step  (st)
	);

	llp_ram #(.WIDTH(4), .DEPTH(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req_ready   = (state_q == S_IDLE) && (!res_valid_q || res_ready);
	assign accept      = req_valid && req_ready;
	assign res_valid   = res_valid_q;
	assign verdict     = verdict_q;
	assign string_done = done_q;

	assign lvl_m1    = level_q - LW'(1);
	assign lvl_m2    = level_q - LW'(2);
	assign ram_raddr = lvl_m2[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lvl_m1[AW-1:0];
		ram_wdata = prod_sym(st.prod, st.len - 2'd1);
		if (state_q == S_PUSH) begin
			ram_we    = 1'b1;
			ram_waddr = wr_idx_q;
			ram_wdata = prod_sym(prod_q, 2'd1);
		end else if (state_q == S_EXAM && st.kind == STEP_EXPAND && st.len >= 2'd2) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			level_q     <= LW'(2);
			top_q       <= SYM_S;
			failed_q    <= VER_OK;
			tsym_q      <= SYM_END;
			end_q       <= 1'b0;
			cont_q      <= 1'b0;
			prod_q      <= PR_NONE;
			wr_idx_q    <= '0;
			res_valid_q <= 1'b0;
			verdict_q   <= VER_OK;
			done_q      <= 1'b0;
		end else begin
			if (res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						end_q  <= end_of_string;
						tsym_q <= end_of_string ? SYM_END : classify(ch);
						if (failed_q == VER_OK) begin
							state_q <= S_EXAM;
						end else begin
							res_valid_q <= 1'b1;
							verdict_q   <= failed_q;
							done_q      <= end_of_string;
							if (end_of_string) begin
								level_q  <= LW'(2);
								top_q    <= SYM_S;
								failed_q <= VER_OK;
							end
						end
					end
				end
				S_EXAM: begin
					case (st.kind)
						STEP_EXPAND: begin
							if (st.len == 2'd0) begin
								level_q <= lvl_m1;
								cont_q  <= 1'b1;
								state_q <= S_LOAD;
							end else begin
								top_q    <= prod_sym(st.prod, 2'd0);
								level_q  <= lvl_m1 + LW'(st.len);
								prod_q   <= st.prod;
								wr_idx_q <= level_q[AW-1:0];
								state_q  <= (st.len == 2'd3) ? S_PUSH : S_EXAM;
							end
						end
						STEP_MATCH: begin
							level_q  <= lvl_m1;
							failed_q <= st.verdict;
							if (st.verdict == VER_OK) begin
								cont_q  <= 1'b0;
								state_q <= S_LOAD;
							end else begin
								state_q     <= S_IDLE;
								res_valid_q <= 1'b1;
								verdict_q   <= st.verdict;
								done_q      <= end_q;
								if (end_q) begin
									level_q  <= LW'(2);
									top_q    <= SYM_S;
									failed_q <= VER_OK;
								end
							end
						end
						default: begin
							failed_q    <= st.verdict;
							state_q     <= S_IDLE;
							res_valid_q <= 1'b1;
							verdict_q   <= st.verdict;
							done_q      <= end_q;
							if (end_q) begin
								level_q  <= LW'(2);
								top_q    <= SYM_S;
								failed_q <= VER_OK;
							end
						end
					endcase
				end
				S_PUSH: begin
					state_q <= S_EXAM;
				end
				S_LOAD: begin
					top_q <= (level_q == LW'(1)) ? SYM_END : ram_rdata;
					if (cont_q) begin
						state_q <= S_EXAM;
					end else begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b1;
						verdict_q   <= VER_OK;
						done_q      <= end_q;
						if (end_q) begin
							level_q  <= LW'(2);
							top_q    <= SYM_S;
							failed_q <= VER_OK;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, level_q} <= (LW + 1)'(STACK_DEPTH))
		else $error("stack level beyond depth");

	a_busy_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !res_valid_q)
		else $error("result slot occupied while parsing");

	a_done_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && done_q |-> level_q == LW'(2) && top_q == SYM_S && failed_q == VER_OK)
		else $error("stack not restored after end of string");

	a_failed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q != VER_OK |-> state_q == S_IDLE)
		else $error("sticky outcome set while parsing");

endmodule
